### rtl/led_blink_request_sequencer_top_assert.svh
// -----------------------------------------------------------------------------
// led blink request sequencer assertion macros
// shared property forms used by the top level checks
// -----------------------------------------------------------------------------
`ifndef LED_BLINK_REQUEST_SEQUENCER_TOP_ASSERT_SVH
`define LED_BLINK_REQUEST_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define LBRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lbrs_pkg.sv
// -----------------------------------------------------------------------------
// lbrs_pkg
// types and constants shared by the led blink request sequencer modules
// -----------------------------------------------------------------------------
package lbrs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index taken from the word address bit
   localparam logic CSR_SUPPRESSED_ID = 1'b0;

   typedef enum logic {
      KIND_ENQUEUE = 1'b0,
      KIND_TICK    = 1'b1
   } kind_type;

   typedef struct packed {
      logic [15:0] reps;
      logic [15:0] on_len;
      logic [15:0] off_len;
      logic [7:0]  ident;
   } req_type;

   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } fifo_ops_type;

   typedef struct packed {
      logic step;
      logic tick;
      logic queue_empty;
   } player_ctrl_type;

   typedef struct packed {
      logic written;
      logic level;
      logic busy;
      logic pop;
   } player_rsp_type;

endpackage

### rtl/lbrs_fifo.sv
// -----------------------------------------------------------------------------
// lbrs_fifo
// circular request queue held in a synchronous memory with pointers and count
// -----------------------------------------------------------------------------
module lbrs_fifo
   import lbrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fifo_ops_type                       ops,
   input  req_type                            wr_data,
   output req_type                            rd_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_next,
   output logic                               full,
   output logic                               empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   req_type          store_ff [QUEUE_DEPTH];
   req_type          rd_data_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (ops.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (ops.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ops.push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
      if (ops.rd_en) begin
         rd_data_ff <= store_ff[rd_ptr_ff];
      end
   end

   assign rd_data    = rd_data_ff;
   assign count      = count_ff;
   assign count_next = count_in;
   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);

endmodule

### rtl/lbrs_player.sv
// -----------------------------------------------------------------------------
// lbrs_player
// blink sequencer: loads the oldest request and times on and off phases
// -----------------------------------------------------------------------------
module lbrs_player
   import lbrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  player_ctrl_type ctrl,
   input  req_type         head_req,
   input  logic [7:0]      suppressed_id,
   output player_rsp_type  rsp
);

   req_type     active_ff, active_in;
   logic        busy_ff, busy_in;
   logic [15:0] rep_cnt_ff, rep_cnt_in;
   logic [15:0] on_cnt_ff, on_cnt_in;
   logic [15:0] off_cnt_ff, off_cnt_in;

   logic        drives;
   logic        on_act;
   logic        off_act;
   logic [15:0] on_cnt_upd;
   logic [15:0] off_cnt_upd;

   always_comb begin
      drives      = (active_ff.ident != suppressed_id);
      on_act      = (on_cnt_ff < active_ff.on_len);
      on_cnt_upd  = on_cnt_ff + 16'(on_act);
      off_act     = (on_cnt_upd >= active_ff.on_len) && (off_cnt_ff < active_ff.off_len);
      off_cnt_upd = off_cnt_ff + 16'(off_act);

      active_in   = active_ff;
      busy_in     = busy_ff;
      rep_cnt_in  = rep_cnt_ff;
      on_cnt_in   = on_cnt_ff;
      off_cnt_in  = off_cnt_ff;
      rsp         = '0;

      if (ctrl.step && ctrl.tick) begin
         if (!busy_ff) begin
            if (!ctrl.queue_empty) begin
               active_in  = head_req;
               busy_in    = 1'b1;
               rep_cnt_in = '0;
               on_cnt_in  = '0;
               off_cnt_in = '0;
               rsp.pop    = 1'b1;
            end
         end else if (rep_cnt_ff < active_ff.reps) begin
            rsp.written = drives && (on_act || off_act);
            rsp.level   = drives && off_act;
            if ((on_cnt_upd >= active_ff.on_len) && (off_cnt_upd >= active_ff.off_len)) begin
               rep_cnt_in = rep_cnt_ff + 1'b1;
               on_cnt_in  = '0;
               off_cnt_in = '0;
            end else begin
               on_cnt_in  = on_cnt_upd;
               off_cnt_in = off_cnt_upd;
            end
         end else begin
            busy_in = 1'b0;
         end
      end
      rsp.busy = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         busy_ff    <= 1'b0;
         rep_cnt_ff <= '0;
         on_cnt_ff  <= '0;
         off_cnt_ff <= '0;
      end else begin
         active_ff  <= active_in;
         busy_ff    <= busy_in;
         rep_cnt_ff <= rep_cnt_in;
         on_cnt_ff  <= on_cnt_in;
         off_cnt_ff <= off_cnt_in;
      end
   end

endmodule

### rtl/led_blink_request_sequencer_top.sv
// -----------------------------------------------------------------------------
// led_blink_request_sequencer_top
// path: an accepted transfer loads the input stage and the queue memory read register;
// the result register loads when the stage steps, which waits while the output is stalled
// no new transfer is taken while the stage is full; the step writes queue and sequencer state back
// reset: synchronous, clears pointers, count, sequencer state and the register
// -----------------------------------------------------------------------------
module led_blink_request_sequencer_top
   import lbrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [15:0]           req_blink_count,
   input  logic [15:0]           req_on_ticks,
   input  logic [15:0]           req_off_ticks,
   input  logic [7:0]            req_led_id,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pin_written,
   output logic                  rsp_pin_level,
   output logic                  rsp_request_dropped,
   output logic                  rsp_sequencer_busy,
   output logic [3:0]            rsp_queued_count,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic            stage_valid_ff, stage_valid_in;
   logic            stage_kind_ff;
   req_type         stage_req_ff;
   logic            out_valid_ff, out_valid_in;
   logic            out_written_ff;
   logic            out_level_ff;
   logic            out_dropped_ff;
   logic            out_busy_ff;
   logic [3:0]      out_count_ff;
   logic [7:0]      supp_id_ff, supp_id_in;

   logic            accept;
   logic            step;
   logic            is_enqueue;
   logic            dropped;
   fifo_ops_type    fifo_ops;
   req_type         head_req;
   logic [CNT_W-1:0] fifo_count;
   logic [CNT_W-1:0] fifo_count_next;
   logic            fifo_full;
   logic            fifo_empty;
   logic [CNT_W+3:0] count_ext;
   player_ctrl_type play_ctrl;
   player_rsp_type  play_rsp;
   logic            csr_write;

   assign req_stall  = stage_valid_ff || reset;
   assign accept     = req_valid && !req_stall;
   assign step       = stage_valid_ff && (!out_valid_ff || !rsp_stall);
   assign is_enqueue = (stage_kind_ff == KIND_ENQUEUE);
   assign dropped    = step && is_enqueue && fifo_full;

   assign fifo_ops.rd_en = accept;
   assign fifo_ops.push  = step && is_enqueue && !fifo_full;
   assign fifo_ops.pop   = play_rsp.pop;

   assign play_ctrl.step        = step;
   assign play_ctrl.tick        = (stage_kind_ff == KIND_TICK);
   assign play_ctrl.queue_empty = fifo_empty;

   assign count_ext = {4'b0, fifo_count_next};

   lbrs_fifo #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ops        (fifo_ops),
      .wr_data    (stage_req_ff),
      .rd_data    (head_req),
      .count      (fifo_count),
      .count_next (fifo_count_next),
      .full       (fifo_full),
      .empty      (fifo_empty)
   );

   lbrs_player u_player (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (play_ctrl),
      .head_req      (head_req),
      .suppressed_id (supp_id_ff),
      .rsp           (play_rsp)
   );

   // input stage and result register
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (step) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = step || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_kind_ff        <= req_kind;
         stage_req_ff.reps    <= req_blink_count;
         stage_req_ff.on_len  <= req_on_ticks;
         stage_req_ff.off_len <= req_off_ticks;
         stage_req_ff.ident   <= req_led_id;
      end
      if (step) begin
         out_written_ff <= play_rsp.written;
         out_level_ff   <= play_rsp.level;
         out_dropped_ff <= dropped;
         out_busy_ff    <= play_rsp.busy;
         out_count_ff   <= count_ext[3:0];
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pin_written     = out_written_ff;
   assign rsp_pin_level       = out_level_ff;
   assign rsp_request_dropped = out_dropped_ff;
   assign rsp_sequencer_busy  = out_busy_ff;
   assign rsp_queued_count    = out_count_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      supp_id_in = supp_id_ff;
      if (csr_write && (csr_paddr[2] == CSR_SUPPRESSED_ID)) begin
         supp_id_in = csr_pwdata[7:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_SUPPRESSED_ID) begin
         csr_prdata = {{(CSR_DATA_W-8){1'b0}}, supp_id_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supp_id_ff <= '0;
      end else begin
         supp_id_ff <= supp_id_in;
      end
   end

   // checks
`include "led_blink_request_sequencer_top_assert.svh"

   `LBRS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, fifo_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `LBRS_ASSERT_IMP(a_pop_nonempty, clock, reset, fifo_ops.pop, !fifo_empty && !fifo_ops.push, "pop from empty queue")
   `LBRS_ASSERT_NXT(a_drop_full, clock, reset, dropped, fifo_full && rsp_request_dropped, "drop without full queue")
   `LBRS_ASSERT_IMP(a_pin_busy, clock, reset, rsp_valid && rsp_pin_written, rsp_sequencer_busy, "pin driven while idle")

endmodule

### verif/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top: led blink request sequencer testbench
// drives enqueue and tick transfers with bursty sender timing and a patterned
// receiver stall, predicts every result from a local copy of the fifo and
// sequencer state, and compares each result field against the prediction or a directed row's typed result.
// a short directed table covers reset, full fifo drops, both phases in one
// tick, zero counts, suppression and the widest lengths; random transfers
// follow under four suppressed id settings written over the csr port
// -----------------------------------------------------------------------------
module tb_top
   import lbrs_pkg::*;
();

   localparam int DEPTH           = QUEUE_DEPTH_DEFAULT;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_HOLD       = 150;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PLAN_ROWS       = 21;
   localparam logic [CSR_ADDR_W-1:0] SUPPRESSED_ADDR = {CSR_SUPPRESSED_ID, 2'b00};

   typedef struct packed {
      kind_type    kind;
      logic [15:0] blink_count;
      logic [15:0] on_ticks;
      logic [15:0] off_ticks;
      logic [7:0]  led_id;
   } blink_item_type;

   typedef struct packed {
      logic       pin_written;
      logic       pin_level;
      logic       request_dropped;
      logic       sequencer_busy;
      logic [3:0] queued_count;
   } blink_result_type;

   typedef struct packed {
      blink_item_type   item;
      logic             typed_on;
      blink_result_type typed_rsp;
   } plan_row_type;

   localparam blink_result_type UNTYPED = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = 1'b0;
   logic [15:0]           req_blink_count = '0;
   logic [15:0]           req_on_ticks = '0;
   logic [15:0]           req_off_ticks = '0;
   logic [7:0]            req_led_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pin_written;
   logic                  rsp_pin_level;
   logic                  rsp_request_dropped;
   logic                  rsp_sequencer_busy;
   logic [3:0]            rsp_queued_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic long_hold_go = 1'b0;

   // local copy of the fifo and sequencer
   req_type     queued_reqs [DEPTH];
   int          head_idx = 0;
   int          tail_idx = 0;
   int          queued_total = 0;
   logic        playing = 1'b0;
   req_type     playing_req = '0;
   logic [15:0] reps_done = '0;
   logic [15:0] on_done = '0;
   logic [15:0] off_done = '0;
   logic [7:0]  suppressed_copy = 8'h00;

   blink_result_type pending_results [$];
   int               burst_left = 0;
   int               mismatch_count = 0;
   int               transfer_count = 0;
   int               enqueue_count = 0;
   int               drop_count = 0;
   int               pin_write_count = 0;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{'{KIND_TICK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0}},
      '{'{KIND_ENQUEUE, 16'd2,    16'd1,    16'd1,    8'h01}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd1}},
      '{'{KIND_ENQUEUE, 16'd0,    16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd2}},
      '{'{KIND_ENQUEUE, 16'd1,    16'd0,    16'd2,    8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd3}},
      '{'{KIND_ENQUEUE, 16'd2,    16'd0,    16'd0,    8'h5A}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd4}},
      '{'{KIND_ENQUEUE, 16'd1,    16'd3,    16'd0,    8'hA5}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd5}},
      '{'{KIND_ENQUEUE, 16'd30,   16'd0,    16'd0,    8'h33}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd6}},
      '{'{KIND_ENQUEUE, 16'd1,    16'd30,   16'd1,    8'hCC}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd7}},
      '{'{KIND_ENQUEUE, 16'd1,    16'd1,    16'd0,    8'h80}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd8}},
      '{'{KIND_ENQUEUE, 16'd3,    16'd2,    16'd2,    8'h7F}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd8}},
      '{'{KIND_TICK,    16'd0,    16'd0,    16'd0,    8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 4'd7}},
      '{'{KIND_TICK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'd0,    16'd0,    16'd0,    8'h00}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_ENQUEUE, 16'd1,    16'd2,    16'd2,    8'h44}, 1'b0, UNTYPED},
      '{'{KIND_ENQUEUE, 16'd0,    16'd0,    16'd0,    8'h00}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd8}},
      '{'{KIND_TICK,    16'd0,    16'd0,    16'd0,    8'h00}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'd0,    16'd0,    16'd0,    8'h00}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_TICK,    16'd0,    16'd0,    16'd0,    8'h00}, 1'b0, UNTYPED}
   };

   led_blink_request_sequencer_top #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_blink_count     (req_blink_count),
      .req_on_ticks        (req_on_ticks),
      .req_off_ticks       (req_off_ticks),
      .req_led_id          (req_led_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pin_written     (rsp_pin_written),
      .rsp_pin_level       (rsp_pin_level),
      .rsp_request_dropped (rsp_request_dropped),
      .rsp_sequencer_busy  (rsp_sequencer_busy),
      .rsp_queued_count    (rsp_queued_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic blink_result_type predict_blink(input blink_item_type it);
      blink_result_type res;
      logic             drives;
      res = '0;
      if (it.kind == KIND_ENQUEUE) begin
         if (queued_total >= DEPTH) begin
            res.request_dropped = 1'b1;
         end else begin
            queued_reqs[tail_idx].reps    = it.blink_count;
            queued_reqs[tail_idx].on_len  = it.on_ticks;
            queued_reqs[tail_idx].off_len = it.off_ticks;
            queued_reqs[tail_idx].ident   = it.led_id;
            tail_idx = (tail_idx + 1) % DEPTH;
            queued_total++;
         end
      end else if (!playing) begin
         if (queued_total != 0) begin
            playing_req = queued_reqs[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
            queued_total--;
            playing = 1'b1;
            reps_done = '0;
            on_done = '0;
            off_done = '0;
         end
      end else if (reps_done < playing_req.reps) begin
         drives = (playing_req.ident != suppressed_copy);
         if (on_done < playing_req.on_len) begin
            if (drives) begin
               res.pin_written = 1'b1;
               res.pin_level = 1'b0;
            end
            on_done++;
         end
         // off phase may act in the same tick and its write wins
         if (on_done >= playing_req.on_len && off_done < playing_req.off_len) begin
            if (drives) begin
               res.pin_written = 1'b1;
               res.pin_level = 1'b1;
            end
            off_done++;
         end
         if (on_done >= playing_req.on_len && off_done >= playing_req.off_len) begin
            reps_done++;
            on_done = '0;
            off_done = '0;
         end
      end else begin
         playing = 1'b0;
      end
      res.sequencer_busy = playing;
      res.queued_count = 4'(queued_total);
      return res;
   endfunction

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   // called at a rising edge; returns at the edge where the transfer is taken
   task automatic send_item(input blink_item_type it, input logic typed_on,
                            input blink_result_type typed_rsp);
      blink_result_type want;
      int               gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_kind        <= it.kind;
      req_blink_count <= it.blink_count;
      req_on_ticks    <= it.on_ticks;
      req_off_ticks   <= it.off_ticks;
      req_led_id      <= it.led_id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_blink(it);
      if (typed_on) begin
         want = typed_rsp;
      end
      pending_results.push_back(want);
      transfer_count++;
      if (it.kind == KIND_ENQUEUE) begin
         enqueue_count++;
      end
      if (want.request_dropped) begin
         drop_count++;
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [7:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= SUPPRESSED_ADDR;
      csr_pwdata  <= {{(CSR_DATA_W-8){1'b0}}, wdata};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_suppressed(input logic [7:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b1, value, readback);
      suppressed_copy = value;
      csr_access(1'b0, 8'h00, readback);
      check_field("suppressed_id readback", 32'(value), 32'(readback[7:0]));
   endtask

   initial begin : rsp_stall_pattern
      int   stall_mode;
      int   mode_left;
      int   hold_left;
      logic hold_taken;
      stall_mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(4, 60);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 9) < 6);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      blink_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with nothing pending", $time);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("pin_written", 32'(want.pin_written), 32'(rsp_pin_written));
            check_field("pin_level", 32'(want.pin_level), 32'(rsp_pin_level));
            check_field("request_dropped", 32'(want.request_dropped),
                        32'(rsp_request_dropped));
            check_field("sequencer_busy", 32'(want.sequencer_busy),
                        32'(rsp_sequencer_busy));
            check_field("queued_count", 32'(want.queued_count), 32'(rsp_queued_count));
         end
         if (rsp_pin_written) begin
            pin_write_count++;
         end
      end
   end

   initial begin : stimulus
      int             row;
      int             phase;
      int             n;
      int             enq_pct;
      blink_item_type it;
      logic [7:0]     settings [4];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < PLAN_ROWS; row++) begin
         send_item(directed_plan[row].item, directed_plan[row].typed_on,
                   directed_plan[row].typed_rsp);
      end
      // play out the queue, including the long count and on length
      while (playing || queued_total != 0) begin
         it = '{KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)};
         send_item(it, 1'b0, UNTYPED);
      end

      settings[0] = 8'hFF;
      settings[1] = 8'($urandom_range(1, 254));
      settings[2] = 8'h00;
      settings[3] = 8'($urandom_range(1, 254));
      for (phase = 0; phase < 4; phase++) begin
         wait_for_results();
         set_suppressed(settings[phase]);
         enq_pct = $urandom_range(15, 45);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 0 && n == 40) begin
               long_hold_go <= 1'b1;
            end
            it.kind = ($urandom_range(1, 100) <= enq_pct) ? KIND_ENQUEUE : KIND_TICK;
            it.blink_count = 16'($urandom_range(0, 3));
            it.on_ticks = 16'($urandom_range(0, 4));
            it.off_ticks = 16'($urandom_range(0, 4));
            case ($urandom_range(0, 2))
               0: it.led_id = suppressed_copy;
               1: it.led_id = 8'($urandom);
               default: it.led_id = 8'($urandom_range(0, 3));
            endcase
            // zero count with wide lengths ends on its first busy tick
            if ($urandom_range(0, 9) == 0) begin
               it.blink_count = 16'h0000;
               it.on_ticks = 16'($urandom);
               it.off_ticks = 16'($urandom);
            end
            send_item(it, 1'b0, UNTYPED);
         end
      end
      wait_for_results();

      $display("covered %0d transfers: %0d enqueues (%0d dropped), %0d ticks, %0d pin writes",
               transfer_count, enqueue_count, drop_count, transfer_count - enqueue_count,
               pin_write_count);
      $display("suppressed id settings visited: 00 ff %02h 00 %02h", settings[1], settings[3]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/lbrs_pkg.sv
rtl/lbrs_fifo.sv
rtl/lbrs_player.sv
rtl/led_blink_request_sequencer_top.sv
verif/tb_top.sv
